// ===== rtl/core/mbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W    = 8;
    localparam int COORD_W     = 12;
    localparam int CFG_VALUE_W = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd2;

    // configuration reset values and limits
    localparam logic [CFG_VALUE_W-1:0] WIDTH_RESET     = 13'd4096;
    localparam logic [CFG_VALUE_W-1:0] HEIGHT_RESET    = 13'd4096;
    localparam logic [SAMPLE_W-1:0]    THRESHOLD_RESET = 8'd128;
    localparam logic [ROW_W-1:0]       HEIGHT_LIMIT    = 13'd4096;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // side codes of a boundary segment
    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } edge_side_t;

    // one column entry of the line store
    typedef struct packed {
        logic above;
        logic center;
    } line_bits_t;

    // one classified pixel: bit i of sides set means segment with side code i
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [3:0]         sides;
    } edge_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbe_line_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbe_line_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbe_front
    import mbe_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_VALUE_W-1:0] cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_W-1:0]    mask_sample,
    output logic                        push_valid,
    output edge_item_t                  push_item,
    input  wire logic                   queue_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int SW = CW + 2;

    logic [CFG_VALUE_W-1:0] width_reg;
    logic [CFG_VALUE_W-1:0] height_reg;
    logic [SAMPLE_W-1:0]    thr_reg;
    logic [CW-1:0]          col_reg;
    logic [CW-1:0]          col_next;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       row_next;
    line_bits_t             cur_reg;
    line_bits_t             cur_next;
    logic                   left_reg;
    logic                   byp_reg;
    logic                   byp_next;
    line_bits_t             byp_data_reg;

    logic [EW-1:0]          eff_width;
    logic [ROW_W-1:0]       eff_height;
    logic                   accept;
    logic                   sel;
    logic                   last_col;
    logic [SW-1:0]          col_ext;
    logic [SW-1:0]          width_ext;
    logic [SW-1:0]          ahead_sum;
    logic [SW-1:0]          ahead_once;
    logic [SW-1:0]          ahead_twice;
    logic [CW-1:0]          rd_addr;
    line_bits_t             ram_rdata;
    line_bits_t             nxt_bits;
    line_bits_t             wr_bits;
    logic                   nb_left;
    logic                   nb_right;
    logic                   nb_top;
    logic [3:0]             sides;
    logic                   cfg_write;
    logic                   frame_restart;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;

    // width and height writes start a new frame
    assign frame_restart = cfg_write
        && ((cfg_index == CFG_IDX_WIDTH) || (cfg_index == CFG_IDX_HEIGHT));

    // effective width, zero reads as one and large values clamp
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = EW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW'(width_reg);
        end
    end

    // effective height
    always_comb
    begin
        if (height_reg == '0)
        begin
            eff_height = ROW_W'(1);
        end
        else if (height_reg > HEIGHT_LIMIT)
        begin
            eff_height = HEIGHT_LIMIT;
        end
        else
        begin
            eff_height = height_reg;
        end
    end

    // column arithmetic
    assign col_ext   = SW'(col_reg);
    assign width_ext = SW'(eff_width);
    assign last_col  = (col_ext + SW'(1)) >= width_ext;

    // read two columns ahead, wrapping into the next row
    always_comb
    begin
        ahead_sum   = col_ext + SW'(2);
        ahead_once  = (ahead_sum >= width_ext) ? (ahead_sum - width_ext) : ahead_sum;
        ahead_twice = (ahead_once >= width_ext) ? (ahead_once - width_ext) : ahead_once;
        rd_addr     = ahead_twice[CW-1:0];
        byp_next    = (rd_addr == col_reg);
    end

    // classify the pixel one row above the incoming sample
    always_comb
    begin
        sel      = (row_reg < eff_height) && (mask_sample > thr_reg);
        nxt_bits = byp_reg ? byp_data_reg : ram_rdata;
        nb_left  = (col_reg != '0) && left_reg;
        nb_right = !last_col && nxt_bits.center;
        nb_top   = (row_reg >= ROW_W'(2)) && cur_reg.above;
        sides    = {!sel, !nb_top, !nb_right, !nb_left};
        wr_bits  = '{above: cur_reg.center, center: sel};
        cur_next = (eff_width == EW'(1)) ? wr_bits : nxt_bits;
    end

    assign push_valid      = accept && (row_reg != '0) && cur_reg.center && (sides != '0);
    assign push_item.col   = COORD_W'(col_reg);
    assign push_item.row   = COORD_W'(row_reg - ROW_W'(1));
    assign push_item.sides = sides;

    // raster position after this sample
    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = (row_reg >= eff_height) ? '0 : (row_reg + ROW_W'(1));
        end
    end

    // line store, one read ahead and one write per sample
    mbe_line_ram #(
        .WIDTH ($bits(line_bits_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (wr_bits),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // configuration registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THRESHOLD_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IDX_WIDTH:
                    begin
                        width_reg <= cfg_data;
                    end
                    CFG_IDX_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                    end
                    CFG_IDX_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[SAMPLE_W-1:0];
                    end
                    default:
                    begin
                        thr_reg <= thr_reg;
                    end
                endcase
            end
            if (frame_restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                byp_reg <= byp_next;
            end
        end
    end

    // neighbor window, every line store entry is written in row zero before its value is used
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg      <= cur_next;
            left_reg     <= cur_reg.center;
            byp_data_reg <= wr_bits;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbe_queue
    import mbe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  wire edge_item_t push_item,
    output logic      full,
    output logic      head_valid,
    output edge_item_t head_item,
    input  wire logic pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    edge_item_t    slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == NW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_reg + PW'(1));
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_reg + PW'(1));
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbe_back
    import mbe_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire edge_item_t          head_item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [COORD_W-1:0]       pixel_col,
    output logic [COORD_W-1:0]       pixel_row,
    output logic [1:0]               edge_side,
    output logic                     last_edge
);

    logic         busy_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [3:0]   rem_reg;
    logic [3:0]   rem_after;
    logic         out_accept;
    edge_side_t   side;

    assign out_valid  = busy_reg;
    assign out_accept = busy_reg && !out_stall;
    assign rem_after  = rem_reg & (rem_reg - 4'd1);
    assign last_edge  = (rem_after == '0);
    assign pop        = head_valid && (!busy_reg || (out_accept && last_edge));
    assign pixel_col  = col_reg;
    assign pixel_row  = row_reg;
    assign edge_side  = side;

    // lowest pending side goes out first
    always_comb
    begin
        priority if (rem_reg[SIDE_LEFT])
        begin
            side = SIDE_LEFT;
        end
        else if (rem_reg[SIDE_RIGHT])
        begin
            side = SIDE_RIGHT;
        end
        else if (rem_reg[SIDE_TOP])
        begin
            side = SIDE_TOP;
        end
        else
        begin
            side = SIDE_BOTTOM;
        end
    end

    // segment serializer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
        end
        else if (out_accept && last_edge)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg <= head_item.col;
            row_reg <= head_item.row;
            rem_reg <= head_item.sides;
        end
        else if (out_accept)
        begin
            rem_reg <= rem_after;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mask_boundary_edge_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in         in_valid/in_stall    mask_sample
// out       out        out_valid/out_stall  pixel_col, pixel_row, edge_side, last_edge
//
// the front takes one sample per cycle while the two-entry queue has room
// a sample yields zero to four segments, the back sends one segment per cycle while out_stall is low
// line store entries are always written in row zero of a frame before use: no clearing pass
// reset clears counters, queue and serializer and loads the register defaults
// out_stall holds the current segment, in_stall rises only when the queue is full

module mask_boundary_edge_extractor
    import mbe_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_VALUE_W-1:0] cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_W-1:0]    mask_sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [COORD_W-1:0]          pixel_col,
    output logic [COORD_W-1:0]          pixel_row,
    output logic [1:0]                  edge_side,
    output logic                        last_edge
);

    logic       push_valid;
    edge_item_t push_item;
    logic       queue_full;
    logic       head_valid;
    edge_item_t head_item;
    logic       pop;

    // sample intake and classification
    mbe_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mask_sample (mask_sample),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .queue_full  (queue_full)
    );

    // decoupling queue
    mbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // segment output
    mbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .edge_side  (edge_side),
        .last_edge  (last_edge)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mbe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbe_checker
    import mbe_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [COORD_W-1:0]     pixel_col,
    input wire logic [COORD_W-1:0]     pixel_row,
    input wire logic [1:0]             edge_side,
    input wire logic                   last_edge
);

    // a stalled segment holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_col) && $stable(pixel_row)
            && $stable(edge_side) && $stable(last_edge))
        else $error("stalled segment changed");

    // segments of one pixel follow each other with rising side codes
    a_same_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_edge |=> out_valid
            && pixel_col == $past(pixel_col) && pixel_row == $past(pixel_row)
            && edge_side > $past(edge_side))
        else $error("pixel segments broken up");

    // input backpressure only while segments are pending
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output pending");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind mask_boundary_edge_extractor mbe_checker u_mbe_checker (.*);

`default_nettype wire

// ===== tb/tb_mask_boundary_edge_extractor.sv =====
`timescale 1ns / 1ps

module tb_mask_boundary_edge_extractor;
    import mbe_pkg::*;

    localparam int MAX_W          = 4096;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 190;
    localparam int NO_TYPED       = -1;

    // index past the register list, written once and otherwise a filler
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef enum logic {
        STIM_WRITE,
        STIM_SAMPLE
    } stim_kind_t;

    // typed_n is the segment count read off by hand, NO_TYPED leaves it to the predictor
    typedef struct packed {
        stim_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [12:0]          value;
        int                   typed_n;
        logic [COORD_W-1:0]   typed_col;
        logic [COORD_W-1:0]   typed_row;
    } stim_row_t;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        edge_side_t         side;
        logic               is_last;
    } edge_seg_t;

    localparam int NUM_ROWS = 30;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        // reset setting: row zero of a full size frame, nothing comes out
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd255,  0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd129,  0,        12'd0, 12'd0},
        // zero width and zero height act as one
        '{STIM_WRITE,  CFG_IDX_WIDTH,     13'd0,    0,        12'd0, 12'd0},
        '{STIM_WRITE,  CFG_IDX_HEIGHT,    13'd0,    0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd129,  0,        12'd0, 12'd0},
        // padding row releases a lone pixel with all four sides
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd255,  4,        12'd0, 12'd0},
        // sample equal to threshold is unselected
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd128,  0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd255,  0,        12'd0, 12'd0},
        // top threshold: nothing can be selected
        '{STIM_WRITE,  CFG_IDX_THRESHOLD, 13'd255,  0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd255,  0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd255,  0,        12'd0, 12'd0},
        // bottom threshold: any nonzero sample is selected
        '{STIM_WRITE,  CFG_IDX_THRESHOLD, 13'd0,    0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd1,    0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    4,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    0,        12'd0, 12'd0},
        // write to an index past the list is dropped
        '{STIM_WRITE,  CFG_IDX_SPARE,     13'd8191, 0,        12'd0, 12'd0},
        // small region with mixed neighbours
        '{STIM_WRITE,  CFG_IDX_WIDTH,     13'd3,    0,        12'd0, 12'd0},
        '{STIM_WRITE,  CFG_IDX_HEIGHT,    13'd2,    0,        12'd0, 12'd0},
        '{STIM_WRITE,  CFG_IDX_THRESHOLD, 13'd100,  0,        12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd200,  NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd200,  NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd200,  NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd200,  NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd200,  NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    NO_TYPED, 12'd0, 12'd0},
        '{STIM_SAMPLE, CFG_IDX_SPARE,     13'd0,    NO_TYPED, 12'd0, 12'd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_IDX_WIDTH;
    logic [CFG_VALUE_W-1:0] cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    mask_sample = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COORD_W-1:0]     pixel_col;
    logic [COORD_W-1:0]     pixel_row;
    logic [1:0]             edge_side;
    logic                   last_edge;

    // shared between sender, receiver and monitor
    bit                 idle_on = 1'b1;
    bit                 hold_long = 1'b0;
    int                 typed_count = NO_TYPED;
    logic [COORD_W-1:0] typed_col_v = '0;
    logic [COORD_W-1:0] typed_row_v = '0;
    int                 fail_count = 0;
    int                 quiet_cycles = 0;

    // predictor state
    bit [MAX_W-1:0]       center_bits = '0;
    bit [MAX_W-1:0]       above_bits = '0;
    int                   col_pos = 0;
    int                   row_pos = 0;
    logic [12:0]          width_reg = WIDTH_RESET;
    logic [12:0]          height_reg = HEIGHT_RESET;
    logic [SAMPLE_W-1:0]  thr_reg = THRESHOLD_RESET;
    edge_seg_t            released_edges[$];
    edge_seg_t            pending_edges[$];

    mask_boundary_edge_extractor #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mask_sample(mask_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .edge_side  (edge_side),
        .last_edge  (last_edge)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register write as seen by the block
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [12:0] value);
        case (idx)
            CFG_IDX_WIDTH:
            begin
                width_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IDX_HEIGHT:
            begin
                height_reg = value;
                col_pos = 0;
                row_pos = 0;
            end
            CFG_IDX_THRESHOLD:
            begin
                thr_reg = value[SAMPLE_W-1:0];
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_segment(input int c, input int r, input edge_side_t s);
        released_edges.push_back('{c[COORD_W-1:0], r[COORD_W-1:0], s, 1'b0});
    endfunction

    // segments released by one sample: those of the pixel directly above it
    function automatic void classify_sample(input logic [SAMPLE_W-1:0] s);
        int w;
        int h;
        int c;
        int r;
        bit sel;
        bit left_on;
        bit right_on;
        bit top_on;
        released_edges.delete();
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((height_reg > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(height_reg));
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos > h) ? 0 : row_pos;
        sel = (r < h) && (s > thr_reg);
        if (r >= 1 && center_bits[c])
        begin
            left_on = (c > 0) ? above_bits[c - 1] : 1'b0;
            right_on = (c + 1 < w) ? center_bits[c + 1] : 1'b0;
            top_on = (r >= 2) ? above_bits[c] : 1'b0;
            if (!left_on) add_segment(c, r - 1, SIDE_LEFT);
            if (!right_on) add_segment(c, r - 1, SIDE_RIGHT);
            if (!top_on) add_segment(c, r - 1, SIDE_TOP);
            if (!sel) add_segment(c, r - 1, SIDE_BOTTOM);
            if (released_edges.size() > 0)
                released_edges[released_edges.size() - 1].is_last = 1'b1;
        end
        above_bits[c] = center_bits[c];
        center_bits[c] = sel;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r > h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    // predict on accepted transactions and check every accepted segment
    always @(posedge clk)
    begin : monitor
        edge_seg_t want;
        int k;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                classify_sample(mask_sample);
                if (typed_count == NO_TYPED)
                begin
                    foreach (released_edges[j])
                        pending_edges.push_back(released_edges[j]);
                end
                else
                begin
                    for (k = 0; k < typed_count; k++)
                        pending_edges.push_back('{typed_col_v, typed_row_v,
                                                  edge_side_t'(k[1:0]),
                                                  k == typed_count - 1});
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_edges.size() == 0)
                begin
                    $error("segment col %0d row %0d side %0d with nothing expected",
                           pixel_col, pixel_row, edge_side);
                    fail_count++;
                end
                else
                begin
                    want = pending_edges.pop_front();
                    if (pixel_col !== want.col)
                    begin
                        $error("pixel_col expected %0d actual %0d", want.col, pixel_col);
                        fail_count++;
                    end
                    if (pixel_row !== want.row)
                    begin
                        $error("pixel_row expected %0d actual %0d", want.row, pixel_row);
                        fail_count++;
                    end
                    if (edge_side !== want.side)
                    begin
                        $error("edge_side expected %0d actual %0d", want.side, edge_side);
                        fail_count++;
                    end
                    if (last_edge !== want.is_last)
                    begin
                        $error("last_edge expected %0d actual %0d", want.is_last, last_edge);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
                (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_mask_boundary_edge_extractor failed");
                $finish;
            end
        end
    end

    // receiver: random stall per segment, one long hold on request
    initial
    begin
        int stall_n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                stall_n = LONG_HOLD;
            end
            else
                stall_n = idle_on ? $urandom_range(0, 7) : 0;
            if (stall_n > 0)
            begin
                out_stall = 1'b1;
                repeat (stall_n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // wait until every expected segment is out, then let the block go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        settle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_VALUE_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one sample transaction, called and returning at a falling edge
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int n_typed,
                               input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mask_sample = s;
        typed_count = n_typed;
        typed_col_v = c;
        typed_row_v = r;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // sample mostly on the chosen side of the threshold, with some noise
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] thr,
                                                        input int pct);
        if ($urandom_range(0, 7) == 0)
            return SAMPLE_W'($urandom_range(0, 255));
        if ($urandom_range(1, 100) <= pct && thr != 8'd255)
            return SAMPLE_W'($urandom_range(thr + 1, 255));
        return SAMPLE_W'($urandom_range(0, thr));
    endfunction

    initial
    begin
        int i;
        int n_items;
        int pct;
        int random_sent;
        logic [SAMPLE_W-1:0] thr;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table
        for (i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == STIM_WRITE)
                program_register(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].value);
            else
                send_sample(DIRECTED_ROWS[i].value[SAMPLE_W-1:0], DIRECTED_ROWS[i].typed_n,
                            DIRECTED_ROWS[i].typed_col, DIRECTED_ROWS[i].typed_row);
        end

        // oversized width and height saturate, a short burst stays in row zero
        idle_on = ($urandom_range(0, 1) != 0);
        program_register(CFG_IDX_WIDTH, 8191);
        program_register(CFG_IDX_HEIGHT, 8191);
        program_register(CFG_IDX_THRESHOLD, THRESHOLD_RESET);
        for (i = 0; i < 8; i++)
            send_sample(SAMPLE_W'($urandom_range(0, 255)), NO_TYPED, '0, '0);

        // checkerboard while the receiver holds off, so the input backs up
        idle_on = 1'b0;
        program_register(CFG_IDX_WIDTH, 4);
        program_register(CFG_IDX_HEIGHT, 3);
        hold_long = 1'b1;
        for (i = 0; i < 40; i++)
            send_sample((((i + i / 4) % 2) != 0) ? 8'd255 : 8'd0, NO_TYPED, '0, '0);

        // random regions, thresholds and densities
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                program_register(CFG_IDX_WIDTH, $urandom_range(0, 6));
            if ($urandom_range(0, 3) != 0)
                program_register(CFG_IDX_HEIGHT, $urandom_range(0, 5));
            case ($urandom_range(0, 7))
                0: thr = 8'd0;
                1: thr = 8'd255;
                default: thr = SAMPLE_W'($urandom_range(0, 255));
            endcase
            program_register(CFG_IDX_THRESHOLD, thr);
            case ($urandom_range(0, 2))
                0: pct = 10;
                1: pct = 50;
                default: pct = 90;
            endcase
            n_items = $urandom_range(4, 40);
            repeat (n_items) send_sample(pick_sample(thr, pct), NO_TYPED, '0, '0);
            random_sent += n_items;
        end

        settle();
        if (fail_count == 0)
            $display("tb_mask_boundary_edge_extractor passed");
        else
            $display("tb_mask_boundary_edge_extractor failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mbe_pkg.sv
rtl/core/mbe_line_ram.sv
rtl/core/mbe_front.sv
rtl/core/mbe_queue.sv
rtl/core/mbe_back.sv
rtl/core/mask_boundary_edge_extractor.sv
rtl/core/mbe_checker.sv
tb/tb_mask_boundary_edge_extractor.sv
